@@ rtl/i2c_register_access_master_defines.svh @@
// Assertion macros shared by the I2C register access master RTL
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define I2CM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define I2CM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/i2cm_pkg.sv @@
// Types, codes and constants of the I2C register access master
package i2cm_pkg;

	// config register indexes and reset values
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;
	localparam logic [9:0]  HALF_PERIOD_RST = 10'd4;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

	// command codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// byte stages of a transaction
	localparam logic [1:0] STG_DEV  = 2'd0;
	localparam logic [1:0] STG_REG  = 2'd1;
	localparam logic [1:0] STG_DATA = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] LAST_BIT      = 4'd7;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_S_SETUP,
		PH_S_HIGH,
		PH_S_LOW,
		PH_W_LOW,
		PH_W_HIGH,
		PH_A_LOW,
		PH_A_HIGH,
		PH_A_POLL,
		PH_R_LOW,
		PH_R_HIGH,
		PH_K_SETUP,
		PH_K_HIGH,
		PH_K_LOW,
		PH_P_LOW,
		PH_P_HIGH,
		PH_P_REL
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] slave_addr;
		logic [7:0] target_reg;
		logic [7:0] write_data;
		logic [7:0] byte_count;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive_low;
		logic       busy_res;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		logic       failed;
	} rsp_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift_reg;
		logic [7:0]  bytes_left;
		logic [15:0] ack_wait_cnt;
		logic [9:0]  delay_cnt;
		logic [7:0]  dev;
		logic [7:0]  regad;
		logic [7:0]  data;
		logic        is_read;
		logic [1:0]  stage;
		logic        aborted;
	} seq_state_t;

	typedef struct packed {
		logic [9:0]  half_period;
		logic [15:0] ack_timeout;
	} i2cm_cfg_t;

endpackage

@@ rtl/i2cm_if.sv @@
// Valid/ready channels for command words and result words
interface i2cm_cmd_if import i2cm_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface i2cm_rsp_if import i2cm_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/i2cm_step.sv @@
// One-tick next-state and bus-level logic of the I2C sequencer
module i2cm_step import i2cm_pkg::*; (
	input  seq_state_t cur,
	input  cmd_t       cmd,
	input  i2cm_cfg_t  cfg,
	output seq_state_t nxt,
	output rsp_t       rsp
);

	logic [9:0]  dly_inc;
	logic        seg_over;
	logic [9:0]  seg_dly;
	logic [7:0]  smp_shift;
	logic [3:0]  bit_inc;
	logic [15:0] wait_inc;
	logic [7:0]  bytes_dec;

	// segment timer shared by all timed phases
	assign dly_inc   = cur.delay_cnt + 10'd1;
	assign seg_over  = dly_inc >= cfg.half_period;
	assign seg_dly   = seg_over ? 10'd0 : dly_inc;
	assign smp_shift = {cur.shift_reg[6:0], cmd.sda_in};
	assign bit_inc   = cur.bit_index + 4'd1;
	assign wait_inc  = cur.ack_wait_cnt + 16'd1;
	assign bytes_dec = (cur.bytes_left == 8'd0) ? 8'd0 : cur.bytes_left - 8'd1;

	// phase transitions
	always_comb begin
		nxt            = cur;
		rsp.read_byte  = 8'd0;
		rsp.read_valid = 1'b0;
		rsp.read_last  = 1'b0;
		rsp.done_res   = 1'b0;
		rsp.failed     = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (cmd.action == ACT_WRITE || cmd.action == ACT_READ) begin
					nxt.dev          = cmd.slave_addr;
					nxt.regad        = cmd.target_reg;
					nxt.data         = cmd.write_data;
					nxt.is_read      = (cmd.action == ACT_READ);
					nxt.bytes_left   = (cmd.byte_count == 8'd0) ? 8'd1 : cmd.byte_count;
					nxt.stage        = STG_DEV;
					nxt.aborted      = 1'b0;
					nxt.ack_wait_cnt = 16'd0;
					nxt.shift_reg    = cmd.slave_addr;
					nxt.bit_index    = 4'd0;
					nxt.delay_cnt    = 10'd0;
					nxt.phase        = PH_S_SETUP;
				end
			end
			PH_S_SETUP, PH_S_HIGH, PH_W_LOW, PH_A_LOW, PH_R_LOW,
			PH_K_SETUP, PH_K_HIGH, PH_P_LOW, PH_P_HIGH: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					case (cur.phase)
						PH_S_SETUP: nxt.phase = PH_S_HIGH;
						PH_S_HIGH:  nxt.phase = PH_S_LOW;
						PH_W_LOW:   nxt.phase = PH_W_HIGH;
						PH_A_LOW:   nxt.phase = PH_A_HIGH;
						PH_R_LOW:   nxt.phase = PH_R_HIGH;
						PH_K_SETUP: nxt.phase = PH_K_HIGH;
						PH_K_HIGH:  nxt.phase = PH_K_LOW;
						PH_P_LOW:   nxt.phase = PH_P_HIGH;
						PH_P_HIGH:  nxt.phase = PH_P_REL;
						default:    nxt.phase = PH_IDLE;
					endcase
				end
			end
			PH_S_LOW: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.bit_index = 4'd0;
					nxt.phase     = PH_W_LOW;
				end
			end
			PH_W_HIGH: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
					nxt.bit_index = bit_inc;
					nxt.phase     = (bit_inc >= BITS_PER_BYTE) ? PH_A_LOW : PH_W_LOW;
				end
			end
			PH_A_HIGH: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.ack_wait_cnt = 16'd0;
					nxt.phase        = PH_A_POLL;
				end
			end
			PH_A_POLL: begin
				if (!cmd.sda_in) begin
					// acked: move to the next byte of the transaction, or to the stop after the last written byte
					nxt.delay_cnt = 10'd0;
					nxt.bit_index = 4'd0;
					case (cur.stage)
						STG_DEV: begin
							nxt.stage     = STG_REG;
							nxt.shift_reg = cur.regad;
							nxt.phase     = PH_W_LOW;
						end
						STG_REG: begin
							nxt.stage = STG_DATA;
							if (cur.is_read) begin
								nxt.shift_reg = cur.dev + 8'd1;
								nxt.phase     = PH_S_SETUP;
							end else begin
								nxt.shift_reg = cur.data;
								nxt.phase     = PH_W_LOW;
							end
						end
						default: begin
							if (cur.is_read) begin
								nxt.shift_reg = 8'd0;
								nxt.phase     = PH_R_LOW;
							end else begin
								nxt.phase = PH_P_LOW;
							end
						end
					endcase
				end else begin
					nxt.ack_wait_cnt = wait_inc;
					if (wait_inc == 16'd0 || wait_inc >= cfg.ack_timeout) begin
						nxt.aborted   = 1'b1;
						nxt.delay_cnt = 10'd0;
						nxt.phase     = PH_P_LOW;
					end
				end
			end
			PH_R_HIGH: begin
				// sample on the first tick of the high segment
				if (cur.delay_cnt == 10'd0) begin
					nxt.shift_reg = smp_shift;
					if (cur.bit_index == LAST_BIT) begin
						rsp.read_byte  = smp_shift;
						rsp.read_valid = 1'b1;
						rsp.read_last  = (cur.bytes_left <= 8'd1);
					end
				end
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.bit_index = bit_inc;
					nxt.phase     = (bit_inc >= BITS_PER_BYTE) ? PH_K_SETUP : PH_R_LOW;
				end
			end
			PH_K_LOW: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.bytes_left = bytes_dec;
					if (bytes_dec == 8'd0) begin
						nxt.phase = PH_P_LOW;
					end else begin
						nxt.shift_reg = 8'd0;
						nxt.bit_index = 4'd0;
						nxt.phase     = PH_R_LOW;
					end
				end
			end
			PH_P_REL: begin
				nxt.delay_cnt = seg_dly;
				if (seg_over) begin
					nxt.phase    = PH_IDLE;
					rsp.done_res = 1'b1;
					rsp.failed   = cur.aborted;
					nxt.aborted  = 1'b0;
				end
			end
			default: begin
				nxt.phase     = PH_IDLE;
				nxt.delay_cnt = 10'd0;
			end
		endcase

		// bus levels from the updated phase
		rsp.busy_res = (nxt.phase != PH_IDLE);
		case (nxt.phase)
			PH_S_SETUP, PH_A_LOW, PH_R_LOW: begin
				rsp.scl_level     = 1'b0;
				rsp.sda_drive_low = 1'b0;
			end
			PH_S_LOW, PH_P_HIGH: begin
				rsp.scl_level     = 1'b1;
				rsp.sda_drive_low = 1'b1;
			end
			PH_P_LOW: begin
				rsp.scl_level     = 1'b0;
				rsp.sda_drive_low = 1'b1;
			end
			PH_W_LOW: begin
				rsp.scl_level     = 1'b0;
				rsp.sda_drive_low = !nxt.shift_reg[7];
			end
			PH_W_HIGH: begin
				rsp.scl_level     = 1'b1;
				rsp.sda_drive_low = !nxt.shift_reg[7];
			end
			PH_K_SETUP, PH_K_LOW: begin
				rsp.scl_level     = 1'b0;
				rsp.sda_drive_low = (nxt.bytes_left > 8'd1);
			end
			PH_K_HIGH: begin
				rsp.scl_level     = 1'b1;
				rsp.sda_drive_low = (nxt.bytes_left > 8'd1);
			end
			default: begin
				rsp.scl_level     = 1'b1;
				rsp.sda_drive_low = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/i2c_register_access_master.sv @@
// Top level of the I2C register access master: config, sequencer state, result register
//
//  channel | dir | word                                             | accepted when
//  cmd     | in  | action, dev/reg addr, write_data, count, sda_in  | cmd.valid & cmd.ready
//  rsp     | out | bus levels, busy, read byte/valid/last, done     | rsp.valid & rsp.ready
//  cfg     | in  | cfg_we, cfg_idx, cfg_wdata                       | cfg_we
//
// Each command word is one bus tick; it gives exactly one result word.
// A word is accepted per cycle unless stalled; its registered result shows next cycle.
// The result register holds one word; cmd.ready drops only while it is full and stalled.
// arst_n clears the sequencer to idle and loads the config reset values.
`include "i2c_register_access_master_defines.svh"

module i2c_register_access_master import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	i2cm_cmd_if.sink    cmd,
	i2cm_rsp_if.source  rsp
);

	i2cm_cfg_t  cfg_q;
	seq_state_t st_q;
	seq_state_t st_nxt;
	rsp_t       rsp_nxt;
	rsp_t       rsp_q;
	logic       rsp_vld_q;
	logic       acc;

	assign cmd.ready = !rsp_vld_q || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata[9:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	i2cm_step u_step (
		.cur (st_q),
		.cmd (cmd.data),
		.cfg (cfg_q),
		.nxt (st_nxt),
		.rsp (rsp_nxt)
	);

	// sequencer state, advanced once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (acc) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (acc) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_nxt;
		end
	end

	// checks
	`I2CM_ASSERT_IMP(a_full_blocks, rsp_vld_q && !rsp.ready, !cmd.ready, "accept while result stalled")
	`I2CM_ASSERT_NXT(a_hold_state, !acc, $stable(st_q), "state moved without a word")
	`I2CM_ASSERT_IMP(a_done_idle, rsp_vld_q && rsp_q.done_res, !rsp_q.busy_res && st_q.phase == PH_IDLE, "done while busy")
	`I2CM_ASSERT_IMP(a_fail_done, rsp_vld_q && (rsp_q.failed || rsp_q.read_last), rsp_q.done_res || rsp_q.read_valid, "flag without event")
	`I2CM_ASSERT_IMP(a_rd_busy, rsp_vld_q && rsp_q.read_valid, rsp_q.busy_res && st_q.is_read, "read byte outside a read")

endmodule
